/* rtl/pmq_pkg.sv */
// shared types, constants and codes of the priority message queue
// depends on nothing; imported by every module of the block
package pmq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_PRIO    = 31;
    localparam int CMDQ_DEPTH  = 2;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH) + 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CQP_W  = $clog2(CMDQ_DEPTH);
    localparam int CQC_W  = $clog2(CMDQ_DEPTH + 1);
    localparam int CFG_W  = 16;
    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(QUEUE_DEPTH);

    localparam logic       OP_SEND = 1'b0;
    localparam logic       OP_RECV = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_BAD_PRIO = 2'd2;
    localparam logic [1:0] ST_BLOCK    = 2'd3;

    localparam logic       CFG_MAX_MESSAGES = 1'b0;
    localparam logic       CFG_MAX_MSG_SIZE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  prio;
        logic [15:0] msg_len;
        logic [63:0] msg_data;
        logic [15:0] buf_len;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_prio;
        logic [15:0] out_len;
        logic [63:0] out_data;
        logic [6:0]  msg_count;
        logic        wake;
    } out_word_t;

    // classified command between front and back
    typedef struct packed {
        logic        op;
        logic [1:0]  chk;
        logic [7:0]  prio;
        logic [15:0] msg_len;
        logic [63:0] msg_data;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FREE,
        BK_WALK_RD,
        BK_WALK_CHK,
        BK_LINK_SLOT,
        BK_LINK_PREV,
        BK_RECV,
        BK_RESP
    } back_state_t;

endpackage

/* rtl/pmq_front.sv */
// front end: argument checks that need only the word and the size register
// depends on pmq_pkg
module pmq_front (
    input  pmq_pkg::in_word_t req,
    input  logic [15:0]       max_msg_size,
    output pmq_pkg::cmd_t     cmd
);
    import pmq_pkg::*;

    always_comb
    begin
        cmd.op       = req.op;
        cmd.prio     = req.prio;
        cmd.msg_len  = req.msg_len;
        cmd.msg_data = req.msg_data;
        cmd.chk      = ST_OK;
        if (req.op == OP_SEND)
        begin
            if (req.prio > 8'(MAX_PRIO))
                cmd.chk = ST_BAD_PRIO;
            else if (req.msg_len > max_msg_size)
                cmd.chk = ST_BAD_SIZE;
        end
        else if (req.buf_len < max_msg_size)
        begin
            cmd.chk = ST_BAD_SIZE;
        end
    end

endmodule

/* rtl/pmq_cmd_fifo.sv */
// short command queue between front and back
// depends on pmq_pkg
module pmq_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pmq_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output pmq_pkg::cmd_t head_cmd
);
    import pmq_pkg::*;

    cmd_t             mem_reg [CMDQ_DEPTH];
    logic [CQP_W-1:0] wr_reg;
    logic [CQP_W-1:0] rd_reg;
    logic [CQC_W-1:0] fill_reg;

    assign full      = (fill_reg == CQC_W'(CMDQ_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_cmd  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == CQP_W'(CMDQ_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == CQP_W'(CMDQ_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

/* rtl/pmq_back.sv */
// back end: linked-list engine over the entry store, free list and result register
// depends on pmq_pkg
module pmq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  pmq_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    input  logic [6:0]         max_messages,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pmq_pkg::out_word_t rsp
);
    import pmq_pkg::*;

    logic [7:0]  prio_mem [QUEUE_DEPTH];
    logic [15:0] len_mem  [QUEUE_DEPTH];
    logic [63:0] data_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] link_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] link_ok_reg;

    back_state_t state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] free_reg, free_next;
    logic [PTR_W-1:0] slot_reg, slot_next;
    logic [PTR_W-1:0] prev_reg, prev_next;
    logic [PTR_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [7:0]       prio_reg, prio_next;
    out_word_t        res_reg, res_next;
    logic             out_valid_reg;
    out_word_t        out_reg;

    logic [IDX_W-1:0] rd_addr, rd_addr_reg;
    logic [7:0]       rd_prio_reg;
    logic [15:0]      rd_len_reg;
    logic [63:0]      rd_data_reg;
    logic [PTR_W-1:0] rd_link_reg;
    logic             rd_ok_reg;
    logic [PTR_W-1:0] rd_next;

    logic             ent_we;
    logic             link_we;
    logic [IDX_W-1:0] link_addr;
    logic [PTR_W-1:0] link_val;
    logic             out_free;
    logic [CNT_W-1:0] eff_limit;
    logic             free_ok, head_ok, cur_ok, prev_ok;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign eff_limit = (32'(max_messages) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH)
                                                         : CNT_W'(max_messages);
    assign free_ok   = (free_reg < PTR_W'(QUEUE_DEPTH));
    assign head_ok   = (head_reg < PTR_W'(QUEUE_DEPTH));
    assign cur_ok    = (cur_reg  < PTR_W'(QUEUE_DEPTH));
    assign prev_ok   = (prev_reg < PTR_W'(QUEUE_DEPTH));
    // a link never written is taken as the next entry, which forms the initial free chain
    assign rd_next   = rd_ok_reg ? rd_link_reg : PTR_W'(rd_addr_reg) + 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // entry store, registered reads
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            prio_mem[free_reg[IDX_W-1:0]] <= cmd.prio;
            len_mem[free_reg[IDX_W-1:0]]  <= cmd.msg_len;
            data_mem[free_reg[IDX_W-1:0]] <= cmd.msg_data;
        end
        if (link_we)
            link_mem[link_addr] <= link_val;
        rd_addr_reg <= rd_addr;
        rd_prio_reg <= prio_mem[rd_addr];
        rd_len_reg  <= len_mem[rd_addr];
        rd_data_reg <= data_mem[rd_addr];
        rd_link_reg <= link_mem[rd_addr];
        rd_ok_reg   <= link_ok_reg[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.chk != ST_OK)
                        state_next = BK_RESP;
                    else if (cmd.op == OP_SEND)
                        state_next = (count_reg >= eff_limit || !free_ok) ? BK_RESP : BK_FREE;
                    else
                        state_next = (count_reg == '0 || !head_ok) ? BK_RESP : BK_RECV;
                end
            end
            BK_FREE:      state_next = BK_WALK_RD;
            BK_WALK_RD:
                state_next = (!cur_ok || steps_reg == CNT_W'(QUEUE_DEPTH)) ? BK_LINK_SLOT
                                                                           : BK_WALK_CHK;
            BK_WALK_CHK:
                state_next = (prio_reg > rd_prio_reg) ? BK_LINK_SLOT : BK_WALK_RD;
            BK_LINK_SLOT: state_next = BK_LINK_PREV;
            BK_LINK_PREV: state_next = BK_RESP;
            BK_RECV:      state_next = BK_RESP;
            BK_RESP:      state_next = out_free ? BK_IDLE : BK_RESP;
            default:      state_next = BK_IDLE;
        endcase
    end

    // datapath and store controls
    always_comb
    begin
        head_next  = head_reg;
        free_next  = free_reg;
        slot_next  = slot_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        steps_next = steps_reg;
        prio_next  = prio_reg;
        res_next   = res_reg;
        cmd_pop    = 1'b0;
        ent_we     = 1'b0;
        link_we    = 1'b0;
        link_addr  = slot_reg[IDX_W-1:0];
        link_val   = cur_reg;
        rd_addr    = cur_reg[IDX_W-1:0];
        case (state_reg)
            BK_IDLE:
            begin
                rd_addr = (cmd.op == OP_SEND) ? free_reg[IDX_W-1:0] : head_reg[IDX_W-1:0];
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    prio_next = cmd.prio;
                    res_next  = '0;
                    res_next.msg_count = 7'(count_reg);
                    if (cmd.chk != ST_OK)
                        res_next.status = cmd.chk;
                    else if (cmd.op == OP_SEND)
                    begin
                        if (count_reg >= eff_limit || !free_ok)
                            res_next.status = ST_BLOCK;
                        else
                        begin
                            ent_we    = 1'b1;
                            slot_next = free_reg;
                        end
                    end
                    else if (count_reg == '0 || !head_ok)
                        res_next.status = ST_BLOCK;
                end
            end
            BK_FREE:
            begin
                free_next  = rd_next;
                prev_next  = NIL_PTR;
                cur_next   = head_reg;
                steps_next = '0;
            end
            BK_WALK_CHK:
            begin
                if (!(prio_reg > rd_prio_reg))
                begin
                    prev_next  = cur_reg;
                    cur_next   = rd_next;
                    steps_next = steps_reg + 1'b1;
                end
            end
            BK_LINK_SLOT:
            begin
                link_we   = 1'b1;
                link_addr = slot_reg[IDX_W-1:0];
                link_val  = cur_ok ? cur_reg : NIL_PTR;
            end
            BK_LINK_PREV:
            begin
                if (prev_ok)
                begin
                    link_we   = 1'b1;
                    link_addr = prev_reg[IDX_W-1:0];
                    link_val  = slot_reg;
                end
                else
                    head_next = slot_reg;
                res_next.wake      = (count_reg == '0);
                count_next         = count_reg + 1'b1;
                res_next.msg_count = 7'(count_reg + 1'b1);
            end
            BK_RECV:
            begin
                head_next          = rd_next;
                link_we            = 1'b1;
                link_addr          = head_reg[IDX_W-1:0];
                link_val           = free_reg;
                free_next          = head_reg;
                res_next.out_prio  = rd_prio_reg;
                res_next.out_len   = rd_len_reg;
                res_next.out_data  = rd_data_reg;
                res_next.wake      = (count_reg == eff_limit);
                count_next         = count_reg - 1'b1;
                res_next.msg_count = 7'(count_reg - 1'b1);
            end
            default:
            begin
                rd_addr = cur_reg[IDX_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        prio_reg  <= prio_next;
        res_reg   <= res_next;
        if (state_reg == BK_RESP && out_free)
            out_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= NIL_PTR;
            free_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            link_ok_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            if (link_we)
                link_ok_reg[link_addr] <= 1'b1;
            if (state_reg == BK_RESP && out_free)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

/* rtl/priority_message_queue.sv */
// top level of the priority message queue: configuration registers and wiring
// depends on pmq_pkg, pmq_front, pmq_cmd_fifo, pmq_back
//
// bounded priority queue of 64-bit descriptor words kept as a linked list over a
// 64-entry store with a free list; every request word gives exactly one result word
// (status, received message, count and wake flag). the front end checks priority,
// length and buffer size against max_msg_size as the word is accepted and pushes it
// into a two-deep command queue, so req_stall rises only when that queue is full.
// the back end then takes one command at a time: a rejected word (bad size, bad
// priority or would-block) goes straight to the result, a receive unlinks the head,
// and a send passes the queued messages in a sorted walk, each entry a registered
// read, then a compare, before it is linked in. the result sits in one output
// register until taken, and a stalled result holds the back end, which in turn
// fills the command queue. configuration must only be written while no word is in
// flight
module priority_message_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic               cfg_idx,
    input  logic [15:0]        cfg_wdata,
    input  logic               req_valid,
    output logic               req_stall,
    input  pmq_pkg::in_word_t  req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pmq_pkg::out_word_t rsp
);
    import pmq_pkg::*;

    logic [6:0]  max_messages_reg;
    logic [15:0] max_msg_size_reg;
    cmd_t        front_cmd;
    cmd_t        head_cmd;
    logic        q_full, q_valid, q_pop;

    // configuration registers, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_messages_reg <= 7'd10;
            max_msg_size_reg <= 16'd8192;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                CFG_MAX_MESSAGES: max_messages_reg <= cfg_wdata[6:0];
                CFG_MAX_MSG_SIZE: max_msg_size_reg <= cfg_wdata;
                default:          max_msg_size_reg <= max_msg_size_reg;
            endcase
        end
    end

    // input held off only while the command queue is full
    assign req_stall = q_full;

    pmq_front u_front (
        .req          (req),
        .max_msg_size (max_msg_size_reg),
        .cmd          (front_cmd)
    );

    pmq_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid && !q_full),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    pmq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (head_cmd),
        .cmd_pop      (q_pop),
        .max_messages (max_messages_reg),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp)
    );

endmodule

/* dv/pmq_checker.sv */
// checker for the priority message queue: watches both channels, predicts and compares
// depends on pmq_pkg
`timescale 1ns / 1ps

module pmq_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic               cfg_idx,
    input  logic [15:0]        cfg_wdata,
    input  logic               req_valid,
    input  logic               req_stall,
    input  pmq_pkg::in_word_t  req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  pmq_pkg::out_word_t rsp,
    output int                 fail_count,
    output int                 pending,
    output int                 words_checked
);
    import pmq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;

    // queue contents kept as a sorted array, highest priority first
    logic [7:0]  q_prio [$];
    logic [15:0] q_len  [$];
    logic [63:0] q_data [$];
    logic [6:0]  lim_reg;
    logic [15:0] size_reg;
    out_word_t   expected_rsp [$];

    function automatic int eff_limit();
        return (lim_reg > DEPTH) ? DEPTH : int'(lim_reg);
    endfunction

    task automatic apply_op(input in_word_t w);
        out_word_t r;
        int        pos;
        r = '0;
        if (w.op == OP_SEND) begin
            if (w.prio > MAX_PRIO)
                r.status = ST_BAD_PRIO;
            else if (w.msg_len > size_reg)
                r.status = ST_BAD_SIZE;
            else if (q_prio.size() >= eff_limit())
                r.status = ST_BLOCK;
            else begin
                pos = 0;
                while (pos < q_prio.size() && w.prio <= q_prio[pos])
                    pos++;
                r.wake = (q_prio.size() == 0);
                q_prio.insert(pos, w.prio);
                q_len.insert(pos, w.msg_len);
                q_data.insert(pos, w.msg_data);
            end
        end else begin
            if (w.buf_len < size_reg)
                r.status = ST_BAD_SIZE;
            else if (q_prio.size() == 0)
                r.status = ST_BLOCK;
            else begin
                r.out_prio = q_prio.pop_front();
                r.out_len  = q_len.pop_front();
                r.out_data = q_data.pop_front();
                r.wake     = (q_prio.size() + 1 == eff_limit());
            end
        end
        r.msg_count = 7'(q_prio.size());
        expected_rsp.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n) begin
            lim_reg  = 7'd10;
            size_reg = 16'd8192;
            q_prio.delete();
            q_len.delete();
            q_data.delete();
            expected_rsp.delete();
            fail_count    <= 0;
            words_checked <= 0;
            pending       <= 0;
        end else begin
            if (cfg_wen) begin
                if (cfg_idx == CFG_MAX_MESSAGES)
                    lim_reg = cfg_wdata[6:0];
                else
                    size_reg = cfg_wdata;
            end
            if (req_valid && !req_stall)
                apply_op(req);
            if (rsp_valid && !rsp_stall) begin
                words_checked <= words_checked + 1;
                if (expected_rsp.size() == 0) begin
                    if (fail_count < 10)
                        $display("checker: unexpected word %p", rsp);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_rsp.pop_front();
                    if (rsp !== e) begin
                        if (fail_count < 10)
                            $display("checker: mismatch exp %p got %p", e, rsp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_rsp.size();
        end
    end

endmodule

/* dv/tb_top.sv */
// testbench top for the priority message queue: clock, reset, stimulus and verdict
// depends on pmq_pkg, priority_message_queue and pmq_checker
`timescale 1ns / 1ps

module tb_top;
    import pmq_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_wen = 1'b0;
    logic      cfg_idx = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_word_t  req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_word_t rsp;
    int        fail_count, pending, words_checked;

    // idling odds in percent for sender and receiver
    int send_idle = 10;
    int recv_idle = 64;
    bit hold_rsp  = 1'b0;   // long receiver hold-off
    int cycles    = 0;
    int sent      = 0;
    int cur_size  = 8192;   // mirror of max_msg_size for well-formed stimulus

    always #4 clk = ~clk;

    priority_message_queue dut (.*);

    pmq_checker u_chk (.*);

    // random stall on the result side, one assignment per edge
    always @(posedge clk)
    begin
        rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle);
    end

    // hard limit on run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic cfg_write(input logic idx, input int val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= 16'(val);
        if (idx == CFG_MAX_MSG_SIZE)
            cur_size = val;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // offer one word, keeping valid high until it is taken
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drop_valid();
        req_valid <= 1'b0;
    endtask

    // wait until every expected word has come back, then let the back end settle
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic in_word_t mk_send(input int p, input int l, input logic [63:0] d);
        in_word_t w;
        w = '0;
        w.op = OP_SEND;
        w.prio = 8'(p);
        w.msg_len = 16'(l);
        w.msg_data = d;
        w.buf_len = 16'($urandom);
        return w;
    endfunction

    function automatic in_word_t mk_recv(input int b);
        in_word_t w;
        w = '0;
        w.op = OP_RECV;
        w.prio = 8'($urandom);
        w.msg_len = 16'($urandom);
        w.msg_data = {$urandom, $urandom};
        w.buf_len = 16'(b);
        return w;
    endfunction

    // random item: mostly well-formed, some bad prio/size
    function automatic in_word_t rand_word(input int send_bias);
        int k;
        k = $urandom_range(99);
        if ($urandom_range(99) < send_bias) begin
            if (k < 6)
                return mk_send($urandom_range(255, MAX_PRIO + 1), $urandom, {$urandom, $urandom});
            if (k < 12)
                return mk_send($urandom_range(MAX_PRIO), $urandom_range(65535, cur_size),
                               {$urandom, $urandom});
            return mk_send($urandom_range(MAX_PRIO), $urandom_range(cur_size),
                           {$urandom, $urandom});
        end
        if (k < 8)
            return mk_recv(cur_size == 0 ? 0 : $urandom_range(cur_size - 1));
        return mk_recv($urandom_range(65535, cur_size));
    endfunction

    task automatic random_phase(input int n, input int send_bias);
        repeat (n) send_word(rand_word(send_bias));
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: errors on empty queue, field extremes, fifo order within priority
        send_word(mk_recv(16'hffff));
        send_word(mk_recv(0));
        send_word(mk_send(255, 0, '1));
        send_word(mk_send(MAX_PRIO + 1, 0, '0));
        send_word(mk_send(0, 16'hffff, '1));
        send_word(mk_send(0, 8192, '1));
        send_word(mk_send(MAX_PRIO, 0, 64'h0123456789abcdef));
        send_word(mk_send(5, 1, 64'h1));
        send_word(mk_send(5, 2, 64'h2));
        send_word(mk_send(MAX_PRIO, 3, '0));
        for (int i = 0; i < 8; i++)
            send_word(mk_send(i, i, 64'(i)));          // fills to the limit of ten
        send_word(mk_recv(8191));
        send_word(mk_recv(16'hffff));                   // receive from a full queue
        send_word(mk_send(7, 7, 64'h7));
        repeat (10) send_word(mk_recv(8192));
        drain();

        // limit of zero, then limit saturated above the store
        cfg_write(CFG_MAX_MESSAGES, 0);
        cfg_write(CFG_MAX_MSG_SIZE, 65535);
        send_word(mk_send(1, 65535, '1));
        send_word(mk_recv(65535));
        drain();
        cfg_write(CFG_MAX_MESSAGES, 127);
        cfg_write(CFG_MAX_MSG_SIZE, 1);
        random_phase(120, 80);

        // limit lowered below the count, then drained
        cfg_write(CFG_MAX_MESSAGES, 3);
        random_phase(80, 30);
        cfg_write(CFG_MAX_MESSAGES, 64);
        cfg_write(CFG_MAX_MSG_SIZE, 0);

        // long receiver hold-off with sends still offered
        fork
            begin
                hold_rsp = 1'b1;
                repeat (400) @(posedge clk);
                hold_rsp = 1'b0;
            end
            begin
                repeat (20) send_word(rand_word(90));
                drop_valid();
            end
        join
        drain();

        send_idle = 64;
        recv_idle = 10;
        cfg_write(CFG_MAX_MESSAGES, 1);
        cfg_write(CFG_MAX_MSG_SIZE, 300);
        random_phase(80, 55);
        cfg_write(CFG_MAX_MESSAGES, 64);
        random_phase(100, 55);

        send_idle = 0;
        recv_idle = 0;
        cfg_write(CFG_MAX_MESSAGES, 20);
        cfg_write(CFG_MAX_MSG_SIZE, 65535);
        random_phase(100, 50);

        $display("tb_top: %0d words offered, %0d results checked over limits 0..127",
                 sent, words_checked);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

/* filelist.f */
rtl/pmq_pkg.sv
rtl/pmq_front.sv
rtl/pmq_cmd_fifo.sv
rtl/pmq_back.sv
rtl/priority_message_queue.sv
dv/pmq_checker.sv
dv/tb_top.sv
